FILE: rtl/core/foc_pkg.sv
package foc_pkg;

    localparam int ACCEL_STEP   = 128;
    localparam int SINE_ENTRIES = 1024;
    localparam int K_W          = $clog2(SINE_ENTRIES);
    localparam int QTR_ENTRIES  = SINE_ENTRIES / 4;
    localparam int QTR_W        = K_W - 2;
    localparam int X_STEP       = 65536 / SINE_ENTRIES;

    localparam logic [17:0] INV_SQRT3_Q15 = 18'd18919;

    localparam logic [2:0] CFG_OFFSET_A      = 3'd0;
    localparam logic [2:0] CFG_OFFSET_B      = 3'd1;
    localparam logic [2:0] CFG_OFFSET_C      = 3'd2;
    localparam logic [2:0] CFG_CURRENT_GAIN  = 3'd3;
    localparam logic [2:0] CFG_POLE_PAIRS    = 3'd4;
    localparam logic [2:0] CFG_REVERSE_DIR   = 3'd5;
    localparam logic [2:0] CFG_ZERO_OFFSET   = 3'd6;
    localparam logic [2:0] CFG_VIRTUAL_SPEED = 3'd7;

    typedef logic [15:0] t_lut [QTR_ENTRIES];

    function automatic logic [15:0] quarter_sine(input logic [63:0] x);
        logic [63:0] z2;
        logic [63:0] t;
        begin
            z2 = (x * x) << 2;
            t  = 64'd172272;
            t  = 64'd5026995    - ((t * z2) >> 30);
            t  = 64'd85569306   - ((t * z2) >> 30);
            t  = 64'd693598669  - ((t * z2) >> 30);
            t  = 64'd1686629713 - ((t * z2) >> 30);
            t  = (t * x + (64'd1 << 28)) >> 29;
            if (t > 64'd32767) begin
                t = 64'd32767;
            end
            return t[15:0];
        end
    endfunction

    function automatic t_lut build_lut();
        t_lut lut;
        begin
            for (int j = 0; j < QTR_ENTRIES; j++) begin
                lut[j] = quarter_sine(64'(j * X_STEP));
            end
            return lut;
        end
    endfunction

    localparam t_lut        QSINE_LUT = build_lut();
    localparam logic [15:0] QSINE_TOP = quarter_sine(64'd16384);

    function automatic logic signed [15:0] sine_lookup(input logic [K_W-1:0] k);
        logic [QTR_W-1:0] j;
        logic [1:0]       quad;
        logic [15:0]      s;
        begin
            j    = k[QTR_W-1:0];
            quad = k[K_W-1:K_W-2];
            if (quad[0]) begin
                if (j == '0) begin
                    s = QSINE_TOP;
                end else begin
                    s = QSINE_LUT[QTR_W'(QTR_ENTRIES - int'(j))];
                end
            end else begin
                s = QSINE_LUT[j];
            end
            return quad[1] ? -$signed(s) : $signed(s);
        end
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
        begin
            if (v > 40'sd32767) begin
                return 16'sh7FFF;
            end else if (v < -40'sd32768) begin
                return 16'sh8000;
            end
            return v[15:0];
        end
    endfunction

endpackage

FILE: rtl/core/foc_current_to_dq_frontend.sv
// Nine products run on one shared 18x18 multiplier over eleven sequencer steps, then
// one step loads the outputs. Input ready only while the sequencer idles: a new input
// beat is taken only once the last result has been loaded into the outputs.
// A waiting result holds the last step until it is taken.
// Reset (synchronous, active low) restores register defaults and clears the ramp.
module foc_current_to_dq_frontend (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [11:0]         i_raw_a,
    input  logic [11:0]         i_raw_b,
    input  logic [11:0]         i_raw_c,
    input  logic [2:0]          i_sector,
    input  logic [13:0]         i_mech_angle,
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [15:0]  o_d_current,
    output logic signed [15:0]  o_q_current,
    output logic signed [15:0]  o_alpha_current,
    output logic signed [15:0]  o_beta_current,
    output logic [15:0]         o_angle_used,
    output logic [15:0]         o_sensed_angle
);
    import foc_pkg::*;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_ELEC_MUL = 4'd1;
    localparam logic [3:0] ST_ANGLE    = 4'd2;
    localparam logic [3:0] ST_CUR_A    = 4'd3;
    localparam logic [3:0] ST_CUR_B    = 4'd4;
    localparam logic [3:0] ST_CUR_C    = 4'd5;
    localparam logic [3:0] ST_BETA_MUL = 4'd6;
    localparam logic [3:0] ST_BETA     = 4'd7;
    localparam logic [3:0] ST_D_ACC    = 4'd8;
    localparam logic [3:0] ST_D        = 4'd9;
    localparam logic [3:0] ST_Q_ACC    = 4'd10;
    localparam logic [3:0] ST_Q        = 4'd11;
    localparam logic [3:0] ST_LAST     = 4'd12;

    logic [11:0]        r_off_a, r_off_b, r_off_c;
    logic [15:0]        r_gain;
    logic [4:0]         r_pp;
    logic               r_rev;
    logic [15:0]        r_zero;
    logic signed [31:0] r_vspeed;
    logic signed [31:0] r_rspeed;
    logic [31:0]        r_rphase;

    logic [3:0]         r_step;
    logic [11:0]        r_raw_a, r_raw_b, r_raw_c;
    logic [2:0]         r_sector;
    logic [13:0]        r_mech;
    logic signed [35:0] r_prod;
    logic signed [35:0] r_acc;
    logic signed [15:0] r_ia, r_ib, r_alpha, r_beta, r_d, r_q, r_sin, r_cos;
    logic [15:0]        r_used, r_sensed;
    logic               r_ov;

    logic signed [17:0] mul_a, mul_b;
    logic signed [35:0] mul_p;
    logic signed [15:0] cur_sat;
    logic [15:0]        elec, sensed;
    logic signed [32:0] ns;
    logic [31:0]        nphase;
    logic signed [17:0] sum_ab;
    logic signed [39:0] dq_sum;
    logic signed [15:0] ia_rebuilt;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_step == ST_IDLE);
    assign o_valid     = r_ov;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_step)
            ST_ELEC_MUL: begin
                mul_a = 18'(r_mech);
                mul_b = 18'(r_pp);
            end
            ST_ANGLE: begin
                mul_a = 18'($signed({1'b0, r_raw_a}) - $signed({1'b0, r_off_a}));
                mul_b = 18'(r_gain);
            end
            ST_CUR_A: begin
                mul_a = 18'($signed({1'b0, r_raw_b}) - $signed({1'b0, r_off_b}));
                mul_b = 18'(r_gain);
            end
            ST_CUR_B: begin
                mul_a = 18'($signed({1'b0, r_raw_c}) - $signed({1'b0, r_off_c}));
                mul_b = 18'(r_gain);
            end
            ST_BETA_MUL: begin
                mul_a = -sum_ab;
                mul_b = INV_SQRT3_Q15;
            end
            ST_BETA: begin
                mul_a = 18'(r_alpha);
                mul_b = 18'(r_cos);
            end
            ST_D_ACC: begin
                mul_a = 18'(r_beta);
                mul_b = 18'(r_sin);
            end
            ST_D: begin
                mul_a = 18'(r_beta);
                mul_b = 18'(r_cos);
            end
            ST_Q_ACC: begin
                mul_a = 18'(r_alpha);
                mul_b = 18'(r_sin);
            end
            default: ;
        endcase
        mul_p   = mul_a * mul_b;
        cur_sat = sat16(40'(r_prod >>> 8));
        sum_ab  = 18'(r_ia) + (18'(r_ib) <<< 1);

        ia_rebuilt = sat16(-40'(r_ib) - 40'(cur_sat));

        elec   = {r_prod[13:0], 2'b00};
        if (r_rev) begin
            elec = -elec;
        end
        sensed = elec - r_zero;

        ns = 33'(r_rspeed);
        if (r_rspeed < r_vspeed) begin
            ns = 33'(r_rspeed) + 33'(ACCEL_STEP);
            if (ns > 33'(r_vspeed)) begin
                ns = 33'(r_vspeed);
            end
        end
        nphase = r_rphase + ns[31:0];

        dq_sum = 40'(r_acc) + 40'(r_prod);
        if (r_step == ST_Q) begin
            dq_sum = 40'(r_acc) - 40'(r_prod);
        end
        dq_sum = (dq_sum + 40'sd16384) >>> 15;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_a  <= 12'd2048;
            r_off_b  <= 12'd2048;
            r_off_c  <= 12'd2048;
            r_gain   <= 16'd256;
            r_pp     <= 5'd7;
            r_rev    <= 1'b0;
            r_zero   <= 16'd0;
            r_vspeed <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_OFFSET_A:      r_off_a  <= i_cfg_data[11:0];
                CFG_OFFSET_B:      r_off_b  <= i_cfg_data[11:0];
                CFG_OFFSET_C:      r_off_c  <= i_cfg_data[11:0];
                CFG_CURRENT_GAIN:  r_gain   <= i_cfg_data[15:0];
                CFG_POLE_PAIRS:    r_pp     <= i_cfg_data[4:0];
                CFG_REVERSE_DIR:   r_rev    <= i_cfg_data[0];
                CFG_ZERO_OFFSET:   r_zero   <= i_cfg_data[15:0];
                CFG_VIRTUAL_SPEED: r_vspeed <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= ST_IDLE;
            r_ov     <= 1'b0;
            r_rspeed <= '0;
            r_rphase <= '0;
        end else begin
            if (r_ov && i_ready && r_step != ST_LAST) begin
                r_ov <= 1'b0;
            end
            r_prod <= mul_p;
            unique case (r_step)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_raw_a  <= i_raw_a;
                        r_raw_b  <= i_raw_b;
                        r_raw_c  <= i_raw_c;
                        r_sector <= i_sector;
                        r_mech   <= i_mech_angle;
                        r_step   <= ST_ELEC_MUL;
                    end
                end
                ST_ELEC_MUL: begin
                    r_step <= ST_ANGLE;
                end
                ST_ANGLE: begin
                    r_sensed <= sensed;
                    if (r_vspeed != '0) begin
                        r_rspeed <= ns[31:0];
                        r_rphase <= nphase;
                        r_used   <= nphase[31:16];
                    end else begin
                        r_rspeed <= '0;
                        r_rphase <= '0;
                        r_used   <= sensed;
                    end
                    r_step <= ST_CUR_A;
                end
                ST_CUR_A: begin
                    r_ia   <= cur_sat;
                    r_sin  <= sine_lookup(r_used[15 -: K_W]);
                    r_cos  <= sine_lookup(r_used[15 -: K_W] + K_W'(QTR_ENTRIES));
                    r_step <= ST_CUR_B;
                end
                ST_CUR_B: begin
                    r_ib   <= cur_sat;
                    r_step <= ST_CUR_C;
                end
                ST_CUR_C: begin
                    case (r_sector)
                        3'd1, 3'd5: begin
                            r_ib    <= sat16(-40'(r_ia) - 40'(cur_sat));
                            r_alpha <= sat16(-40'(r_ia));
                        end
                        3'd2, 3'd3: begin
                            r_ia    <= ia_rebuilt;
                            r_alpha <= sat16(-40'(ia_rebuilt));
                        end
                        default: begin
                            r_alpha <= sat16(-40'(r_ia));
                        end
                    endcase
                    r_step <= ST_BETA_MUL;
                end
                ST_BETA_MUL: begin
                    r_step <= ST_BETA;
                end
                ST_BETA: begin
                    r_beta <= sat16((40'(r_prod) + 40'sd16384) >>> 15);
                    r_step <= ST_D_ACC;
                end
                ST_D_ACC: begin
                    r_acc  <= r_prod;
                    r_step <= ST_D;
                end
                ST_D: begin
                    r_d    <= sat16(dq_sum);
                    r_step <= ST_Q_ACC;
                end
                ST_Q_ACC: begin
                    r_acc  <= r_prod;
                    r_step <= ST_Q;
                end
                ST_Q: begin
                    r_q    <= sat16(dq_sum);
                    r_step <= ST_LAST;
                end
                ST_LAST: begin
                    if (!r_ov || i_ready) begin
                        o_d_current     <= r_d;
                        o_q_current     <= r_q;
                        o_alpha_current <= r_alpha;
                        o_beta_current  <= r_beta;
                        o_angle_used    <= r_used;
                        o_sensed_angle  <= r_sensed;
                        r_ov            <= 1'b1;
                        r_step          <= ST_IDLE;
                    end
                end
                default: begin
                    r_step <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: tb/testbench.sv
module testbench;
    import foc_pkg::*;

    typedef struct packed {
        logic signed [15:0] d_cur;
        logic signed [15:0] q_cur;
        logic signed [15:0] alpha_cur;
        logic signed [15:0] beta_cur;
        logic [15:0]        angle_used;
        logic [15:0]        sensed_angle;
    } dq_result_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [11:0]        raw_a;
    logic [11:0]        raw_b;
    logic [11:0]        raw_c;
    logic [2:0]         sector;
    logic [13:0]        mech_angle;
    logic               out_valid;
    logic               out_ready;
    logic signed [15:0] d_current;
    logic signed [15:0] q_current;
    logic signed [15:0] alpha_current;
    logic signed [15:0] beta_current;
    logic [15:0]        angle_used;
    logic [15:0]        sensed_angle;

    foc_current_to_dq_frontend u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_valid         (in_valid),
        .o_ready         (in_ready),
        .i_raw_a         (raw_a),
        .i_raw_b         (raw_b),
        .i_raw_c         (raw_c),
        .i_sector        (sector),
        .i_mech_angle    (mech_angle),
        .o_valid         (out_valid),
        .i_ready         (out_ready),
        .o_d_current     (d_current),
        .o_q_current     (q_current),
        .o_alpha_current (alpha_current),
        .o_beta_current  (beta_current),
        .o_angle_used    (angle_used),
        .o_sensed_angle  (sensed_angle)
    );

    // predictor copy of registers and ramp state
    logic [11:0]        mdl_offset_a;
    logic [11:0]        mdl_offset_b;
    logic [11:0]        mdl_offset_c;
    logic [15:0]        mdl_gain;
    logic [4:0]         mdl_pole_pairs;
    logic               mdl_reverse;
    logic [15:0]        mdl_zero_offset;
    logic signed [31:0] mdl_virtual_speed;
    logic signed [31:0] mdl_ramp_speed;
    logic [31:0]        mdl_ramp_phase;

    dq_result_t dq_expected[$];
    int         send_idle_pct;
    int         recv_idle_pct;
    int         error_count;
    int         stall_cycles;
    localparam int STALL_LIMIT = 20000;

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic longint floor_div(input longint v, input int n);
        if (v >= 0) begin
            return v >>> n;
        end
        return -((-v + ((64'sd1 << n) - 1)) >>> n);
    endfunction

    function automatic longint clamp16(input longint v);
        if (v > 32767) begin
            return 32767;
        end
        if (v < -32768) begin
            return -32768;
        end
        return v;
    endfunction

    function automatic longint poly_quarter(input longint unsigned x);
        longint unsigned z2;
        longint unsigned acc;
        z2  = (x * x) << 2;
        acc = 172272;
        acc = 64'd5026995 - ((acc * z2) >> 30);
        acc = 64'd85569306 - ((acc * z2) >> 30);
        acc = 64'd693598669 - ((acc * z2) >> 30);
        acc = 64'd1686629713 - ((acc * z2) >> 30);
        acc = (acc * x + (64'd1 << 28)) >> 29;
        if (acc > 32767) begin
            acc = 32767;
        end
        return longint'(acc);
    endfunction

    function automatic longint angle_sine(input logic [15:0] ang);
        longint unsigned k;
        longint unsigned ph;
        longint unsigned x;
        longint          s;
        k  = (longint'(ang) * SINE_ENTRIES) >> 16;
        ph = ((k * 65536) / SINE_ENTRIES) & 16'hFFFF;
        x  = ph & 16383;
        s  = ph[14] ? poly_quarter(16384 - x) : poly_quarter(x);
        return ph[15] ? -s : s;
    endfunction

    function automatic longint scale_phase(input logic [11:0] raw, input logic [11:0] ofs);
        return clamp16(floor_div((longint'(raw) - longint'(ofs)) * longint'(mdl_gain), 8));
    endfunction

    function automatic dq_result_t predict_dq(input logic [11:0] ra, input logic [11:0] rb,
                                              input logic [11:0] rc, input logic [2:0] sec,
                                              input logic [13:0] mech);
        dq_result_t r;
        logic [15:0] elec;
        logic [15:0] sensed;
        logic [15:0] used;
        longint      ia, ib, ic, al, be, s, c, ns;
        elec = 16'(longint'(mech) * 4 * longint'(mdl_pole_pairs));
        if (mdl_reverse) begin
            elec = 16'(0) - elec;
        end
        sensed = elec - mdl_zero_offset;
        if (mdl_virtual_speed != 0) begin
            if (mdl_ramp_speed < mdl_virtual_speed) begin
                ns = longint'(mdl_ramp_speed) + ACCEL_STEP;
                if (ns > mdl_virtual_speed) begin
                    ns = mdl_virtual_speed;
                end
                mdl_ramp_speed = 32'(ns);
            end
            mdl_ramp_phase = mdl_ramp_phase + mdl_ramp_speed;
            used = mdl_ramp_phase[31:16];
        end else begin
            mdl_ramp_speed = 0;
            mdl_ramp_phase = 0;
            used = sensed;
        end
        ia = scale_phase(ra, mdl_offset_a);
        ib = scale_phase(rb, mdl_offset_b);
        ic = scale_phase(rc, mdl_offset_c);
        case (sec)
            3'd1, 3'd5: ib = clamp16(-ia - ic);
            3'd2, 3'd3: ia = clamp16(-ib - ic);
            default: ;
        endcase
        al = clamp16(-ia);
        be = clamp16(floor_div(-(ia + 2 * ib) * 18919 + 16384, 15));
        s  = angle_sine(used);
        c  = angle_sine(used + 16'd16384);
        r.d_cur        = 16'(clamp16(floor_div(al * c + be * s + 16384, 15)));
        r.q_cur        = 16'(clamp16(floor_div(be * c - al * s + 16384, 15)));
        r.alpha_cur    = 16'(al);
        r.beta_cur     = 16'(be);
        r.angle_used   = used;
        r.sensed_angle = sensed;
        return r;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_OFFSET_A:      mdl_offset_a      = val[11:0];
            CFG_OFFSET_B:      mdl_offset_b      = val[11:0];
            CFG_OFFSET_C:      mdl_offset_c      = val[11:0];
            CFG_CURRENT_GAIN:  mdl_gain          = val[15:0];
            CFG_POLE_PAIRS:    mdl_pole_pairs    = val[4:0];
            CFG_REVERSE_DIR:   mdl_reverse       = val[0];
            CFG_ZERO_OFFSET:   mdl_zero_offset   = val[15:0];
            CFG_VIRTUAL_SPEED: mdl_virtual_speed = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic send_sample(input logic [11:0] ra, input logic [11:0] rb,
                               input logic [11:0] rc, input logic [2:0] sec,
                               input logic [13:0] mech);
        while ($urandom_range(99) < send_idle_pct) @(posedge clk);
        in_valid   <= 1'b1;
        raw_a      <= ra;
        raw_b      <= rb;
        raw_c      <= rc;
        sector     <= sec;
        mech_angle <= mech;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        dq_expected.push_back(predict_dq(ra, rb, rc, sec, mech));
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_random_sample();
        logic [11:0] ra, rb, rc;
        int          pick;
        pick = $urandom_range(9);
        ra = (pick == 0) ? 12'($urandom_range(1) * 4095) : 12'($urandom);
        rb = (pick == 1) ? 12'($urandom_range(1) * 4095) : 12'($urandom);
        rc = (pick == 2) ? 12'($urandom_range(1) * 4095) : 12'($urandom);
        send_sample(ra, rb, rc, 3'($urandom), 14'($urandom));
    endtask

    task automatic drain();
        while (dq_expected.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic test_reset_defaults();
        send_sample(12'd2048, 12'd2048, 12'd2048, 3'd0, 14'd0);
        send_sample(12'd4095, 12'd0, 12'd4095, 3'd0, 14'd16383);
        send_sample(12'd0, 12'd4095, 12'd0, 3'd7, 14'd2341);
        for (int s = 1; s <= 6; s++) begin
            send_sample(12'($urandom), 12'($urandom), 12'($urandom), 3'(s), 14'($urandom));
        end
        drain();
    endtask

    task automatic test_saturation();
        write_reg(CFG_CURRENT_GAIN, 32'd65535);
        write_reg(CFG_OFFSET_A, 32'd4095);
        write_reg(CFG_OFFSET_B, 32'd0);
        write_reg(CFG_OFFSET_C, 32'd0);
        send_sample(12'd0, 12'd4095, 12'd4095, 3'd0, 14'd100);
        send_sample(12'd0, 12'd4095, 12'd4095, 3'd2, 14'd9000);
        send_sample(12'd4095, 12'd0, 12'd0, 3'd1, 14'd4096);
        send_sample(12'd0, 12'd0, 12'd4095, 3'd4, 14'd12288);
        drain();
        write_reg(CFG_CURRENT_GAIN, 32'd0);
        write_reg(CFG_POLE_PAIRS, 32'd0);
        send_sample(12'd4095, 12'd0, 12'd77, 3'd3, 14'd16383);
        drain();
    endtask

    task automatic test_angle_config();
        write_reg(CFG_CURRENT_GAIN, 32'd300);
        write_reg(CFG_OFFSET_A, 32'd2000);
        write_reg(CFG_OFFSET_B, 32'd2100);
        write_reg(CFG_OFFSET_C, 32'd2048);
        write_reg(CFG_POLE_PAIRS, 32'd31);
        write_reg(CFG_REVERSE_DIR, 32'd1);
        write_reg(CFG_ZERO_OFFSET, 32'd65535);
        send_sample(12'd3000, 12'd1000, 12'd2048, 3'd5, 14'd16383);
        send_sample(12'd1000, 12'd3000, 12'd2048, 3'd6, 14'd1);
        drain();
        write_reg(CFG_POLE_PAIRS, 32'd1);
        write_reg(CFG_REVERSE_DIR, 32'd0);
        write_reg(CFG_ZERO_OFFSET, 32'd0);
        for (int a = 0; a < 8; a++) begin
            send_sample(12'd3000, 12'd1500, 12'd2000, 3'd0, 14'(a * 2048 + 1));
        end
        drain();
    endtask

    task automatic test_virtual_ramp();
        write_reg(CFG_VIRTUAL_SPEED, 32'h7FFF_FFFF);
        repeat (6) send_random_sample();
        drain();
        write_reg(CFG_VIRTUAL_SPEED, 32'h8000_0000);
        repeat (3) send_random_sample();
        drain();
        write_reg(CFG_VIRTUAL_SPEED, 32'd300);
        repeat (5) send_random_sample();
        drain();
        write_reg(CFG_VIRTUAL_SPEED, 32'd0);
        drain();
    endtask

    task automatic randomize_config();
        write_reg(CFG_OFFSET_A, $urandom_range(4095));
        write_reg(CFG_OFFSET_B, $urandom_range(4095));
        write_reg(CFG_OFFSET_C, $urandom_range(4095));
        write_reg(CFG_CURRENT_GAIN, $urandom_range(3) == 0 ? $urandom : $urandom_range(1024));
        write_reg(CFG_POLE_PAIRS, $urandom_range(31));
        write_reg(CFG_REVERSE_DIR, $urandom_range(1));
        write_reg(CFG_ZERO_OFFSET, $urandom_range(65535));
        case ($urandom_range(3))
            0:       write_reg(CFG_VIRTUAL_SPEED, 32'd0);
            1:       write_reg(CFG_VIRTUAL_SPEED, $urandom);
            default: write_reg(CFG_VIRTUAL_SPEED, $urandom_range(20000, 1));
        endcase
    endtask

    task automatic test_random(input int n_items);
        for (int i = 0; i < n_items; i++) begin
            if (i % 100 == 0) begin
                drain();
                randomize_config();
            end
            if (i == n_items / 2) begin
                drain();
            end
            send_random_sample();
        end
        drain();
    endtask

    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (dq_expected.size() == 0) begin
                    $display("%0t: result beat with nothing expected", $time);
                    error_count++;
                end else begin
                    if ({d_current, q_current, alpha_current, beta_current,
                         angle_used, sensed_angle} != dq_expected[0]) begin
                        $display("%0t: mismatch exp d=%0d q=%0d al=%0d be=%0d ang=%0d sen=%0d",
                                 $time, dq_expected[0].d_cur, dq_expected[0].q_cur,
                                 dq_expected[0].alpha_cur, dq_expected[0].beta_cur,
                                 dq_expected[0].angle_used, dq_expected[0].sensed_angle);
                        $display("%0t:          act d=%0d q=%0d al=%0d be=%0d ang=%0d sen=%0d",
                                 $time, d_current, q_current, alpha_current, beta_current,
                                 angle_used, sensed_angle);
                        error_count++;
                    end
                    void'(dq_expected.pop_front());
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
            || !rst_n) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        error_count   = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rst_n      <= 1'b0;
        cfg_valid  <= 1'b0;
        cfg_index  <= CFG_OFFSET_A;
        cfg_data   <= '0;
        in_valid   <= 1'b0;
        raw_a      <= '0;
        raw_b      <= '0;
        raw_c      <= '0;
        sector     <= '0;
        mech_angle <= '0;
        out_ready  <= 1'b1;
        mdl_offset_a      = 12'd2048;
        mdl_offset_b      = 12'd2048;
        mdl_offset_c      = 12'd2048;
        mdl_gain          = 16'd256;
        mdl_pole_pairs    = 5'd7;
        mdl_reverse       = 1'b0;
        mdl_zero_offset   = 16'd0;
        mdl_virtual_speed = 32'sd0;
        mdl_ramp_speed    = 32'sd0;
        mdl_ramp_phase    = 32'd0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_saturation();
        test_angle_config();
        test_virtual_ramp();
        send_idle_pct = 36;
        recv_idle_pct = 81;
        test_random(530);
        send_idle_pct = 81;
        recv_idle_pct = 36;
        test_random(530);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(540);

        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/foc_pkg.sv
rtl/core/foc_current_to_dq_frontend.sv
tb/testbench.sv
